>>> rtl/rsscd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rsscd_pkg;

  // Width of the fixed screen-coordinate fields.
  localparam int REG_BITS  = 16;
  localparam int OUT_BITS  = 17;
  localparam int LEN_BITS  = 7;
  localparam int BYTE_BITS = 8;
  localparam int IDX_BITS  = 3;

  localparam logic [REG_BITS-1:0] CLIP_RIGHT_RESET  = 16'd640;
  localparam logic [REG_BITS-1:0] CLIP_BOTTOM_RESET = 16'd480;

  // Bit 7 of a control byte flags a transparent run; the low bits are the count.
  localparam logic [BYTE_BITS-1:0] RUN_FLAG = 8'h80;
  localparam logic [BYTE_BITS-1:0] RUN_MASK = 8'h7F;

  typedef enum logic [IDX_BITS-1:0] {
    CFG_SPRITE_X      = 3'd0,
    CFG_SPRITE_Y      = 3'd1,
    CFG_SPRITE_WIDTH  = 3'd2,
    CFG_SPRITE_HEIGHT = 3'd3,
    CFG_CLIP_LEFT     = 3'd4,
    CFG_CLIP_TOP      = 3'd5,
    CFG_CLIP_RIGHT    = 3'd6,
    CFG_CLIP_BOTTOM   = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_CTRL = 2'd0,
    MODE_DATA = 2'd1
  } parse_mode_t;

  // Visible window derived from the configuration registers.
  typedef struct packed {
    logic signed [REG_BITS-1:0] sprite_x;
    logic signed [REG_BITS-1:0] sprite_y;
    logic signed [OUT_BITS-1:0] vx0;
    logic signed [OUT_BITS-1:0] vx1;
    logic signed [OUT_BITS-1:0] vy0;
    logic signed [OUT_BITS-1:0] vy1;
    logic                       empty;
  } window_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] span_x;
    logic signed [OUT_BITS-1:0] span_y;
    logic        [LEN_BITS-1:0] span_length;
    logic                       done_res;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/rle_sprite_clip_span_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Run-length sprite span decoder with clipping. Sprite bytes arrive one per
// request on the in_ channel; in_tuser marks the first byte of a new sprite
// and restarts the parser. Each opaque run is clipped against both the sprite
// box and the clip rectangle, and its visible part leaves on the out_ channel
// as one span (x, y, length). After the last visible row ends, a marker with
// zero length and out_tlast high closes the sprite. The block takes one byte
// every cycle unless the output stalls; a byte is held in the input register and
// parsed from there, and its span is registered in the result register. The parser
// update (mode, run counter, row and column) sets the rate and feeds the next byte's
// clip arithmetic. The user must write configuration registers over the cfg_ port
// only while no sprite is in flight (not enforced); they act on the next byte.
module rle_sprite_clip_span_decoder #(
  parameter int COORD_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rle_byte
  input  wire logic        in_tuser,   // [0] first_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [16:0] span_x, [33:17] span_y, [40:34] span_length
  output logic             out_tlast,  // done_res
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  rsscd_pkg::window_t win;
  rsscd_pkg::result_t res, out_r;
  logic               res_valid;

  // Input register: holds one accepted byte until the parser takes it.
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] byte_r;
  logic       first_r;
  logic       out_valid_r, out_valid_nxt;
  logic       step;

  // The parser advances whenever a byte is held and the result register is
  // free or being emptied in the same cycle.
  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) in_valid_nxt = 1'b1;
    else if (step)              in_valid_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step)            out_valid_nxt = res_valid;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r  <= in_tdata;
      first_r <= in_tuser;
    end
    if (step && res_valid) out_r <= res;
  end

  rsscd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .win       (win)
  );

  rsscd_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .rle_byte   (byte_r),
    .first_byte (first_r),
    .win        (win),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_r.span_length, out_r.span_y, out_r.span_x};
  assign out_tlast  = out_r.done_res;

endmodule

`default_nettype wire

>>> rtl/rsscd_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module rsscd_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [rsscd_pkg::IDX_BITS-1:0]     cfg_index,
  input  wire logic [rsscd_pkg::REG_BITS-1:0]     cfg_data,
  output rsscd_pkg::window_t                      win
);

  logic signed [15:0] sprite_x_r, sprite_y_r, clip_left_r, clip_top_r;
  logic signed [15:0] clip_right_r, clip_bottom_r;
  logic        [15:0] sprite_width_r, sprite_height_r;

  logic signed [17:0] x_end, y_end;
  logic signed [17:0] vx0_w, vx1_w, vy0_w, vy1_w;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sprite_x_r      <= '0;
      sprite_y_r      <= '0;
      sprite_width_r  <= '0;
      sprite_height_r <= '0;
      clip_left_r     <= '0;
      clip_top_r      <= '0;
      clip_right_r    <= rsscd_pkg::CLIP_RIGHT_RESET;
      clip_bottom_r   <= rsscd_pkg::CLIP_BOTTOM_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        rsscd_pkg::CFG_SPRITE_X:      sprite_x_r      <= cfg_data;
        rsscd_pkg::CFG_SPRITE_Y:      sprite_y_r      <= cfg_data;
        rsscd_pkg::CFG_SPRITE_WIDTH:  sprite_width_r  <= cfg_data;
        rsscd_pkg::CFG_SPRITE_HEIGHT: sprite_height_r <= cfg_data;
        rsscd_pkg::CFG_CLIP_LEFT:     clip_left_r     <= cfg_data;
        rsscd_pkg::CFG_CLIP_TOP:      clip_top_r      <= cfg_data;
        rsscd_pkg::CFG_CLIP_RIGHT:    clip_right_r    <= cfg_data;
        rsscd_pkg::CFG_CLIP_BOTTOM:   clip_bottom_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // The far edges of the sprite box need two extra bits before the clip.
  assign x_end = {{2{sprite_x_r[15]}}, sprite_x_r} + {2'b00, sprite_width_r};
  assign y_end = {{2{sprite_y_r[15]}}, sprite_y_r} + {2'b00, sprite_height_r};

  always_comb begin
    vx0_w = (sprite_x_r > clip_left_r) ? {{2{sprite_x_r[15]}}, sprite_x_r}
                                       : {{2{clip_left_r[15]}}, clip_left_r};
    vy0_w = (sprite_y_r > clip_top_r)  ? {{2{sprite_y_r[15]}}, sprite_y_r}
                                       : {{2{clip_top_r[15]}}, clip_top_r};
    vx1_w = {{2{clip_right_r[15]}}, clip_right_r};
    if (x_end < vx1_w) vx1_w = x_end;
    vy1_w = {{2{clip_bottom_r[15]}}, clip_bottom_r};
    if (y_end < vy1_w) vy1_w = y_end;
  end

  // The clipped edges always lie in the 16-bit signed range, so 17 bits hold them.
  assign win.sprite_x = sprite_x_r;
  assign win.sprite_y = sprite_y_r;
  assign win.vx0      = vx0_w[16:0];
  assign win.vx1      = vx1_w[16:0];
  assign win.vy0      = vy0_w[16:0];
  assign win.vy1      = vy1_w[16:0];
  assign win.empty    = (vx1_w <= vx0_w) || (vy1_w <= vy0_w);

endmodule

`default_nettype wire

>>> rtl/rsscd_core.sv
`timescale 1ns / 1ps
`default_nettype none

module rsscd_core #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                step,
  input  wire logic [rsscd_pkg::BYTE_BITS-1:0]     rle_byte,
  input  wire logic                                first_byte,
  input  wire rsscd_pkg::window_t                  win,
  output logic                                     res_valid,
  output rsscd_pkg::result_t                       res
);

  localparam int AW = ((COORD_BITS > 17) ? COORD_BITS : 17) + 2;
  localparam int LW = rsscd_pkg::LEN_BITS;

  rsscd_pkg::parse_mode_t mode_r, mode_nxt, mode_eff;
  logic [LW-1:0]          left_r, left_nxt, left_eff, left_dec;
  logic [COORD_BITS-1:0]  row_r, row_nxt, row_eff, row_sat;
  logic [COORD_BITS-1:0]  col_r, col_nxt, col_eff, col_sat;
  logic                   fin_r, fin_nxt, fin_eff;
  logic [COORD_BITS:0]    col_sum;
  logic [LW-1:0]          run_len;

  logic signed [AW-1:0] y_a, start_a, end_a, lo_a, hi_a, diff_a;
  logic signed [AW-1:0] vx0_a, vx1_a, vy0_a, vy1_a;
  logic                 is_end, is_skip, row_last, span_vis;

  // A first byte restarts the parser before the byte itself is parsed.
  always_comb begin
    if (first_byte) begin
      mode_eff = rsscd_pkg::MODE_CTRL;
      left_eff = '0;
      row_eff  = '0;
      col_eff  = '0;
      fin_eff  = win.empty;
    end else begin
      mode_eff = mode_r;
      left_eff = left_r;
      row_eff  = row_r;
      col_eff  = col_r;
      fin_eff  = fin_r;
    end
  end

  assign run_len  = rle_byte[LW-1:0];
  assign is_end   = (rle_byte == '0);
  assign is_skip  = ((rle_byte & rsscd_pkg::RUN_FLAG) != '0);
  assign left_dec = (left_eff != '0) ? left_eff - 1'b1 : left_eff;
  assign col_sum  = {1'b0, col_eff} + {{(COORD_BITS + 1 - LW){1'b0}}, run_len};
  assign col_sat  = col_sum[COORD_BITS] ? '1 : col_sum[COORD_BITS-1:0];
  assign row_sat  = (&row_eff) ? row_eff : row_eff + 1'b1;

  assign vx0_a   = {{(AW-17){win.vx0[16]}}, win.vx0};
  assign vx1_a   = {{(AW-17){win.vx1[16]}}, win.vx1};
  assign vy0_a   = {{(AW-17){win.vy0[16]}}, win.vy0};
  assign vy1_a   = {{(AW-17){win.vy1[16]}}, win.vy1};
  assign y_a     = {{(AW-16){win.sprite_y[15]}}, win.sprite_y}
                 + {{(AW-COORD_BITS){1'b0}}, row_eff};
  assign start_a = {{(AW-16){win.sprite_x[15]}}, win.sprite_x}
                 + {{(AW-COORD_BITS){1'b0}}, col_eff};
  assign end_a   = start_a + {{(AW-LW){1'b0}}, run_len};
  assign lo_a    = (start_a > vx0_a) ? start_a : vx0_a;
  assign hi_a    = (end_a < vx1_a) ? end_a : vx1_a;
  assign diff_a  = hi_a - lo_a;

  assign row_last = (y_a >= vy1_a - AW'(1));
  assign span_vis = (y_a >= vy0_a) && (y_a < vy1_a) && (hi_a > lo_a);

  // Next parser state.
  always_comb begin
    mode_nxt = mode_eff;
    left_nxt = left_eff;
    row_nxt  = row_eff;
    col_nxt  = col_eff;
    fin_nxt  = fin_eff;
    if (!fin_eff) begin
      if (mode_eff == rsscd_pkg::MODE_DATA) begin
        left_nxt = left_dec;
        if (left_dec == '0) mode_nxt = rsscd_pkg::MODE_CTRL;
      end else begin
        mode_nxt = rsscd_pkg::MODE_CTRL;
        if (is_end) begin
          row_nxt = row_sat;
          col_nxt = '0;
          if (row_last) fin_nxt = 1'b1;
        end else if (is_skip) begin
          col_nxt = col_sat;
        end else begin
          mode_nxt = rsscd_pkg::MODE_DATA;
          left_nxt = run_len;
          col_nxt  = col_sat;
        end
      end
    end
  end

  // Result of this byte, if any.
  always_comb begin
    res_valid       = 1'b0;
    res.span_x      = lo_a[16:0];
    res.span_y      = y_a[16:0];
    res.span_length = diff_a[LW-1:0];
    res.done_res    = 1'b0;
    if (!fin_eff && (mode_eff != rsscd_pkg::MODE_DATA)) begin
      if (is_end) begin
        res_valid       = row_last;
        res.span_x      = '0;
        res.span_length = '0;
        res.done_res    = 1'b1;
      end else if (!is_skip) begin
        res_valid = span_vis;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= rsscd_pkg::MODE_CTRL;
      left_r <= '0;
      row_r  <= '0;
      col_r  <= '0;
      fin_r  <= 1'b1;
    end else if (step) begin
      mode_r <= mode_nxt;
      left_r <= left_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      fin_r  <= fin_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rsscd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rsscd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic        out_tlast
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // The sprite-done marker carries zero length and zero x.
  a_done_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> (out_tdata[40:34] == 7'd0) && (out_tdata[16:0] == 17'd0))
    else $error("done marker with nonzero length or x");

  // An ordinary span always shades at least one pixel.
  a_span_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[40:34] != 7'd0)
    else $error("empty span emitted");

  // The padding above the packed fields stays zero.
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[47:41] == 7'd0)
    else $error("nonzero padding in result");

endmodule

bind rle_sprite_clip_span_decoder rsscd_checker u_rsscd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

>>> test/rle_sprite_clip_span_decoder_test.sv
`timescale 1ns / 1ps

module rle_sprite_clip_span_decoder_test;

  localparam int HALF_PERIOD   = 10;
  localparam int SETTLE_CYCLES = 6;        // covers the input and result registers plus margin
  localparam int DRAIN_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 300;      // long output hold-off that backs up the input
  localparam int PHASE_BYTES   = 50;
  localparam int TIMEOUT_NS    = 10_000_000;

  // Kinds of window setting used by the random part.
  localparam int WIN_TYPICAL     = 0;
  localparam int WIN_LOW_CORNER  = 1;
  localparam int WIN_HIGH_CORNER = 2;
  localparam int WIN_EXTREME     = 3;

  // Tracks the parser and the clip window of the block, and keeps the spans
  // that accepted bytes are expected to produce, oldest first.
  class span_scoreboard;
    logic [rsscd_pkg::REG_BITS-1:0] regs [8];
    rsscd_pkg::parse_mode_t         mode;
    logic [6:0]                     data_left;
    logic [15:0]                    row;
    logic [15:0]                    col;
    bit                             finished;
    rsscd_pkg::result_t             expected_spans [$];
    int                             mismatches;
    int                             spans_seen;
    int                             markers_seen;
    int                             bytes_seen;

    function new();
      foreach (regs[i]) regs[i] = '0;
      regs[rsscd_pkg::CFG_CLIP_RIGHT]  = rsscd_pkg::CLIP_RIGHT_RESET;
      regs[rsscd_pkg::CFG_CLIP_BOTTOM] = rsscd_pkg::CLIP_BOTTOM_RESET;
      mode         = rsscd_pkg::MODE_CTRL;
      data_left    = '0;
      row          = '0;
      col          = '0;
      finished     = 1'b1;
      mismatches   = 0;
      spans_seen   = 0;
      markers_seen = 0;
      bytes_seen   = 0;
    endfunction

    function void write_reg(rsscd_pkg::cfg_reg_t idx, logic [rsscd_pkg::REG_BITS-1:0] value);
      regs[idx] = value;
    endfunction

    // Row and column counters stick at their maximum instead of wrapping.
    function logic [15:0] add_clamped(logic [15:0] a, int n);
      int s;
      s = int'(a) + n;
      return (s > 65535) ? 16'hFFFF : s[15:0];
    endfunction

    function void decode_byte(logic [7:0] b, bit first);
      int                 sx, sy, w, h, vx0, vx1, vy0, vy1;
      int                 y, start, lo, hi, len;
      rsscd_pkg::result_t r;
      bytes_seen++;
      sx = $signed(regs[rsscd_pkg::CFG_SPRITE_X]);
      sy = $signed(regs[rsscd_pkg::CFG_SPRITE_Y]);
      w  = regs[rsscd_pkg::CFG_SPRITE_WIDTH];
      h  = regs[rsscd_pkg::CFG_SPRITE_HEIGHT];
      vx0 = $signed(regs[rsscd_pkg::CFG_CLIP_LEFT]);
      vx1 = $signed(regs[rsscd_pkg::CFG_CLIP_RIGHT]);
      vy0 = $signed(regs[rsscd_pkg::CFG_CLIP_TOP]);
      vy1 = $signed(regs[rsscd_pkg::CFG_CLIP_BOTTOM]);
      if (sx > vx0) vx0 = sx;
      if (sx + w < vx1) vx1 = sx + w;
      if (sy > vy0) vy0 = sy;
      if (sy + h < vy1) vy1 = sy + h;

      if (first) begin
        mode      = rsscd_pkg::MODE_CTRL;
        data_left = '0;
        row       = '0;
        col       = '0;
        finished  = (vx1 <= vx0) || (vy1 <= vy0);
      end
      if (finished) return;

      // Data bytes of an opaque run carry pixels only; just count them off.
      if (mode == rsscd_pkg::MODE_DATA) begin
        if (data_left != 0) data_left--;
        if (data_left == 0) mode = rsscd_pkg::MODE_CTRL;
        return;
      end

      y = sy + int'(row);
      if (b == 8'h00) begin
        row = add_clamped(row, 1);
        col = '0;
        if (y >= vy1 - 1) begin
          finished      = 1'b1;
          r.span_x      = '0;
          r.span_y      = y[rsscd_pkg::OUT_BITS-1:0];
          r.span_length = '0;
          r.done_res    = 1'b1;
          expected_spans.push_back(r);
        end
        return;
      end
      if ((b & rsscd_pkg::RUN_FLAG) != 0) begin
        col = add_clamped(col, int'(b & rsscd_pkg::RUN_MASK));
        return;
      end

      start     = sx + int'(col);
      lo        = (start > vx0) ? start : vx0;
      hi        = (start + int'(b) < vx1) ? start + int'(b) : vx1;
      mode      = rsscd_pkg::MODE_DATA;
      data_left = b[6:0];
      col       = add_clamped(col, int'(b));
      if (y >= vy0 && y < vy1 && hi > lo) begin
        len           = hi - lo;
        r.span_x      = lo[rsscd_pkg::OUT_BITS-1:0];
        r.span_y      = y[rsscd_pkg::OUT_BITS-1:0];
        r.span_length = len[rsscd_pkg::LEN_BITS-1:0];
        r.done_res    = 1'b0;
        expected_spans.push_back(r);
      end
    endfunction

    function void check_span(rsscd_pkg::result_t got);
      rsscd_pkg::result_t want;
      if (expected_spans.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected span x=%0d y=%0d len=%0d done=%0b", got.span_x,
                   got.span_y, got.span_length, got.done_res);
        return;
      end
      want = expected_spans.pop_front();
      if (want.done_res) markers_seen++;
      else spans_seen++;
      if (got.span_x !== want.span_x || got.span_y !== want.span_y ||
          got.span_length !== want.span_length || got.done_res !== want.done_res) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"ERROR: span mismatch, expected x=%0d y=%0d len=%0d done=%0b,",
                    " got x=%0d y=%0d len=%0d done=%0b"},
                   want.span_x, want.span_y, want.span_length, want.done_res,
                   got.span_x, got.span_y, got.span_length, got.done_res);
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = '0;
  logic [15:0] cfg_data   = '0;

  span_scoreboard sb = new();

  // Idle percentages for the current phase, and the hold-off bookkeeping.
  // The stimulus only bumps hold_asked; the ready process owns the count.
  int send_gap_pct = 0;
  int stall_pct    = 0;
  int hold_asked   = 0;
  int hold_taken   = 0;
  int hold_left    = 0;
  int input_stalls = 0;
  int settings     = 0;

  logic [rsscd_pkg::REG_BITS-1:0] window_regs [8];

  rle_sprite_clip_span_decoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // The receiver either runs a long hold-off when one is asked for, or
  // stalls at random with the probability of the current phase.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_asked != hold_taken) begin
      out_tready <= 1'b0;
      hold_taken = hold_asked;
      hold_left  = HOLD_CYCLES - 1;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  // Every span that leaves the block is checked against the oldest
  // expectation. The result fields sit in out_tdata from bit 0 up:
  // span_x, span_y, span_length; the done flag travels on out_tlast.
  always @(posedge clk) begin : span_watch
    rsscd_pkg::result_t got;
    got.span_x      = out_tdata[16:0];
    got.span_y      = out_tdata[33:17];
    got.span_length = out_tdata[40:34];
    got.done_res    = out_tlast;
    if (rst_n && out_tvalid && out_tready) sb.check_span(got);
    if (rst_n && in_tvalid && !in_tready) input_stalls++;
  end

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  // Offers one sprite byte, with random gaps in front of it, and hands it to
  // the scoreboard at the edge where the request is taken. The valid is left
  // high so that back-to-back bytes need no toggle.
  task automatic send_byte(input logic [7:0] b, input bit first);
    while ($urandom_range(99, 0) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= first;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.decode_byte(b, first);
  endtask

  // Waits until every expected span has arrived, then lets the block settle,
  // since bytes that produce nothing may still be in the pipeline.
  task automatic drain();
    in_tvalid <= 1'b0;
    for (int c = 0; c < DRAIN_LIMIT && sb.expected_spans.size() != 0; c++)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window();
    rsscd_pkg::cfg_reg_t idx;
    idx = idx.first();
    do begin
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= window_regs[idx];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(idx, window_regs[idx]);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_valid <= 1'b0;
    settings++;
  endtask

  function automatic void set_window(int sx, int sy, int w, int h, int cl, int ct, int cr,
                                     int cb);
    window_regs[rsscd_pkg::CFG_SPRITE_X]      = sx[15:0];
    window_regs[rsscd_pkg::CFG_SPRITE_Y]      = sy[15:0];
    window_regs[rsscd_pkg::CFG_SPRITE_WIDTH]  = w[15:0];
    window_regs[rsscd_pkg::CFG_SPRITE_HEIGHT] = h[15:0];
    window_regs[rsscd_pkg::CFG_CLIP_LEFT]     = cl[15:0];
    window_regs[rsscd_pkg::CFG_CLIP_TOP]      = ct[15:0];
    window_regs[rsscd_pkg::CFG_CLIP_RIGHT]    = cr[15:0];
    window_regs[rsscd_pkg::CFG_CLIP_BOTTOM]   = cb[15:0];
  endfunction

  function automatic void pick_window(int kind);
    int cl, ct;
    case (kind)
      WIN_LOW_CORNER: begin
        // Sprite hugging the most negative screen corner.
        set_window(-32768 + rand_between(0, 20), -32768 + rand_between(0, 3),
                   rand_between(1, 300), rand_between(1, 5), -32768, -32768, 32767, 32767);
      end
      WIN_HIGH_CORNER: begin
        // Huge sprite whose box runs past the most positive screen corner.
        set_window(32767 - rand_between(0, 60), 32767 - rand_between(1, 6), 65535, 65535,
                   -32768, -32768, 32767, 32767);
      end
      WIN_EXTREME: begin
        foreach (window_regs[i]) begin
          case ($urandom_range(4, 0))
            0:       window_regs[i] = 16'h8000;
            1:       window_regs[i] = 16'h7FFF;
            2:       window_regs[i] = 16'h0000;
            3:       window_regs[i] = 16'hFFFF;
            default: window_regs[i] = 16'($urandom_range(65535, 0));
          endcase
        end
      end
      default: begin
        cl = rand_between(-40, 40);
        ct = rand_between(-10, 10);
        set_window(cl + rand_between(-40, 40), ct + rand_between(-4, 4),
                   rand_between(0, 100), rand_between(0, 8),
                   cl, ct, cl + rand_between(0, 80), ct + rand_between(0, 8));
      end
    endcase
  endfunction

  // Builds a well-formed sprite of random runs and sends it. A few rows lose
  // their end byte, and now and then a stray restart lands inside the stream.
  task automatic send_sprite(input int rows);
    logic [8:0] stream [$];
    int         runs;
    int         len;
    for (int r = 0; r < rows; r++) begin
      runs = rand_between(0, 4);
      for (int k = 0; k < runs; k++) begin
        if ($urandom_range(2, 0) == 0) begin
          len = ($urandom_range(3, 0) == 0) ? rand_between(0, 127) : rand_between(0, 15);
          stream.push_back({1'b0, rsscd_pkg::RUN_FLAG | 8'(len)});
        end else begin
          case ($urandom_range(59, 0))
            0:       len = 127;
            1, 2:    len = rand_between(13, 126);
            default: len = rand_between(1, 6);
          endcase
          stream.push_back({1'b0, 8'(len)});
          repeat (len) stream.push_back({1'b0, 8'($urandom_range(255, 0))});
        end
      end
      if ($urandom_range(29, 0) != 0) stream.push_back({1'b0, 8'h00});
    end
    if (stream.size() == 0) stream.push_back({1'b0, 8'h00});
    stream[0][8] = 1'b1;
    if ($urandom_range(9, 0) == 0) stream[$urandom_range(stream.size() - 1, 0)][8] = 1'b1;
    foreach (stream[i]) send_byte(stream[i][7:0], stream[i][8]);
  endtask

  initial begin : stimulus
    int gap_pct  [4] = '{0, 81, 0, 25};
    int hold_pct [4] = '{0, 0, 81, 25};
    int mark;
    int kind;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Out of reset the sprite box is empty: a byte without a
    // start flag is ignored, and a new sprite is clipped away at once.
    send_byte(8'h00, 1'b0);
    send_byte(8'h05, 1'b1);
    drain();

    // Sprite at (10, 20), 200 wide and 3 rows tall, in the default clip.
    set_window(10, 20, 200, 3, 0, 0, 640, 480);
    write_window();
    send_byte(8'hFF, 1'b1);           // transparent run of 127
    send_byte(8'hC2, 1'b0);           // transparent run of 66
    send_byte(8'h7F, 1'b0);           // longest opaque run, cut at the right edge
    send_byte(8'h00, 1'b0);           // data bytes are never parsed as controls
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b1);           // restart inside the data: full 127 span
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b1);           // restart on a row end, top row is not the last
    send_byte(8'h80, 1'b0);           // transparent run of zero
    send_byte(8'h01, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);           // last visible row ends: done marker
    send_byte(8'h01, 1'b0);           // ignored while idle
    drain();

    // Random part, one phase per idle pattern.
    for (int m = 0; m < 4; m++) begin
      send_gap_pct = gap_pct[m];
      stall_pct    = hold_pct[m];
      mark         = sb.bytes_seen;
      while (sb.bytes_seen - mark < PHASE_BYTES) begin
        drain();
        case ($urandom_range(9, 0))
          0:       kind = WIN_LOW_CORNER;
          1:       kind = WIN_HIGH_CORNER;
          2:       kind = WIN_EXTREME;
          default: kind = WIN_TYPICAL;
        endcase
        pick_window(kind);
        write_window();
        repeat (rand_between(1, 2)) send_sprite(rand_between(1, 8));
      end

      if (m == 0) begin
        // Back-pressure: the receiver holds off while a dense sprite keeps
        // coming, so the block has to stall its input.
        drain();
        set_window(0, 0, 640, 8, 0, 0, 640, 480);
        write_window();
        hold_asked++;
        send_byte(8'h01, 1'b1);
        send_byte(8'h3C, 1'b0);
        repeat (19) begin
          send_byte(8'h01, 1'b0);
          send_byte(8'($urandom_range(255, 0)), 1'b0);
        end
        repeat (8) send_byte(8'h00, 1'b0);
      end
    end

    drain();
    $display("Run covered %0d accepted bytes over %0d window settings, with gaps, stalls",
             sb.bytes_seen, settings);
    $display("and one long hold-off (%0d input stall cycles); %0d spans, %0d end markers.",
             input_stalls, sb.spans_seen, sb.markers_seen);
    if (sb.expected_spans.size() != 0)
      $display("ERROR: %0d expected spans never arrived", sb.expected_spans.size());
    if (sb.mismatches == 0 && sb.expected_spans.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("ERROR: timeout");
    $display("Verification failed");
    $finish;
  end

endmodule
